[src/wrms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared types, constants and the control store of the windowed rms meter.
// ----------------------------------------------------------------------------
package wrms_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int COUNT_W    = 13;
    localparam int SUM_W      = 43;
    localparam int SQUARE_W   = 31;
    localparam int QUOT_W     = 31;
    localparam int ROOT_W     = 16;
    localparam int SREM_W     = 17;
    localparam int LOOP_W     = 5;
    localparam int PC_W       = 3;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 32;

    localparam int WINDOW_MAX   = 4096;
    localparam int WINDOW_RESET = 1024;

    // iterations minus one of each loop
    localparam logic [LOOP_W-1:0] DIV_LAST  = LOOP_W'(QUOT_W - 1);
    localparam logic [LOOP_W-1:0] SQRT_LAST = LOOP_W'(ROOT_W - 1);

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE      = 3'd0;
    localparam pc_t PC_SQUARE    = 3'd1;
    localparam pc_t PC_ACCUM     = 3'd2;
    localparam pc_t PC_CHECK     = 3'd3;
    localparam pc_t PC_DIV_STEP  = 3'd4;
    localparam pc_t PC_SQRT_INIT = 3'd5;
    localparam pc_t PC_SQRT_STEP = 3'd6;
    localparam pc_t PC_EMIT      = 3'd7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_NO_REQ,
        C_NOT_CLOSE,
        C_LOOP,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // control store: one word per step
    function automatic ctrl_word_t ucode(input pc_t pc);
        ctrl_word_t cw;
        cw = '{in_ready: 1'b0, op: OP_NONE, cond: C_NEXT, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:      cw = '{1'b1, OP_LOAD,      C_NO_REQ,    PC_IDLE};
            PC_SQUARE:    cw = '{1'b0, OP_SQUARE,    C_NEXT,      PC_IDLE};
            PC_ACCUM:     cw = '{1'b0, OP_ACCUM,     C_NEXT,      PC_IDLE};
            PC_CHECK:     cw = '{1'b0, OP_DIV_INIT,  C_NOT_CLOSE, PC_IDLE};
            PC_DIV_STEP:  cw = '{1'b0, OP_DIV_STEP,  C_LOOP,      PC_DIV_STEP};
            PC_SQRT_INIT: cw = '{1'b0, OP_SQRT_INIT, C_NEXT,      PC_IDLE};
            PC_SQRT_STEP: cw = '{1'b0, OP_SQRT_STEP, C_LOOP,      PC_SQRT_STEP};
            PC_EMIT:      cw = '{1'b0, OP_EMIT,      C_OUT_BUSY,  PC_EMIT};
            default:      cw = '{1'b0, OP_NONE,      C_NEXT,      PC_IDLE};
        endcase
        return cw;
    endfunction

endpackage

[src/windowed_rms_level_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_level_meter
// Windowed rms level of signed 16-bit audio, driven by a small microprogram.
// ----------------------------------------------------------------------------
// Each accepted sample is squared and added to the open window. The window
// closes when it holds window_length samples (0 reads as 1, values above 4096
// read as 4096) or when a sample arrives with s_tlast set; the block then
// returns floor(sqrt(floor(sum / count))) as unsigned Q1.15 (0..32768) with
// the number of samples in the window. A sample that does not close a window
// is squared, accumulated and checked before the next one can be taken.
// A closing sample also runs the bit-serial divider (one quotient bit per
// cycle) and the digit-by-digit square root (one root bit per cycle), plus
// the sequencer steps around them; an extra wait occurs only if the
// previous result has not yet been taken from the output register. The result
// register is independent of the input side, so new samples are accepted while
// a result waits. window_length is written through cfg_valid/cfg_data; write
// it only while no window close is in progress.
// ----------------------------------------------------------------------------
module windowed_rms_level_meter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration: window_length
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wrms_pkg::COUNT_W-1:0]           cfg_data,
    // input request
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [wrms_pkg::TDATA_IN_W-1:0]        s_tdata,   // [15:0] sample
    input  logic                                   s_tlast,   // end_of_data
    // result request
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [wrms_pkg::TDATA_OUT_W-1:0]       m_tdata    // [15:0] rms_level,
                                                              // [28:16] samples_in_window,
                                                              // [31:29] zero
);

    // sequencer
    wrms_pkg::pc_t        pc_reg, pc_next;
    wrms_pkg::ctrl_word_t cw;
    logic [wrms_pkg::LOOP_W-1:0] loop_reg, loop_next;
    logic jump;

    // configuration
    logic [wrms_pkg::COUNT_W-1:0] len_reg, len_next;
    logic [wrms_pkg::COUNT_W-1:0] eff_len;

    // window state
    logic [wrms_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [wrms_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         last_reg, last_next;

    // datapath
    logic [wrms_pkg::SAMPLE_W-1:0] mag_reg, mag_next;
    logic [wrms_pkg::SQUARE_W-1:0] sq_reg, sq_next;
    logic [2*wrms_pkg::SAMPLE_W-1:0] product;

    logic [wrms_pkg::COUNT_W-1:0]  drem_reg, drem_next;
    logic [wrms_pkg::QUOT_W-1:0]   dq_reg, dq_next;
    logic [wrms_pkg::COUNT_W+1:0]  div_diff;

    logic [2*wrms_pkg::ROOT_W-1:0] srad_reg, srad_next;
    logic [wrms_pkg::ROOT_W-1:0]   sroot_reg, sroot_next;
    logic [wrms_pkg::SREM_W-1:0]   srem_reg, srem_next;
    logic [wrms_pkg::SREM_W+1:0]   sqrt_part, sqrt_trial, sqrt_diff;
    logic                          sqrt_ge;

    // output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [wrms_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [wrms_pkg::COUNT_W-1:0]   nsamp_reg, nsamp_next;

    logic accept;
    logic out_busy;
    logic close_win;

    assign cw        = wrms_pkg::ucode(pc_reg);
    assign s_tready  = cw.in_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && cw.in_ready;
    assign out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(wrms_pkg::TDATA_OUT_W - wrms_pkg::COUNT_W - wrms_pkg::LEVEL_W){1'b0}},
                       nsamp_reg, level_reg};

    // window length limited to 1..WINDOW_MAX
    always_comb begin
        if (len_reg == '0) begin
            eff_len = wrms_pkg::COUNT_W'(1);
        end else if (len_reg > wrms_pkg::COUNT_W'(wrms_pkg::WINDOW_MAX)) begin
            eff_len = wrms_pkg::COUNT_W'(wrms_pkg::WINDOW_MAX);
        end else begin
            eff_len = len_reg;
        end
    end

    assign close_win = (count_reg >= eff_len) || last_reg;

    // step sequencing: taken jump goes to the word's target
    always_comb begin
        unique case (cw.cond)
            wrms_pkg::C_NEXT:      jump = 1'b0;
            wrms_pkg::C_NO_REQ:    jump = !s_tvalid;
            wrms_pkg::C_NOT_CLOSE: jump = !close_win;
            wrms_pkg::C_LOOP:      jump = (loop_reg != '0);
            wrms_pkg::C_OUT_BUSY:  jump = out_busy;
            default:               jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : wrms_pkg::pc_t'(pc_reg + wrms_pkg::pc_t'(1));
    end

    // arithmetic of one divider step: shift in next dividend bit, try subtract
    assign div_diff = {1'b0, drem_reg, dq_reg[wrms_pkg::QUOT_W-1]}
                    - {2'b00, count_reg};

    // arithmetic of one square root step: bring down two bits, try subtract
    assign sqrt_part  = {srem_reg, srad_reg[2*wrms_pkg::ROOT_W-1 -: 2]};
    assign sqrt_trial = {1'b0, sroot_reg, 2'b01};
    assign sqrt_ge    = (sqrt_part >= sqrt_trial);
    assign sqrt_diff  = sqrt_part - sqrt_trial;

    assign product = mag_reg * mag_reg;

    always_comb begin
        len_next      = len_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        mag_next      = mag_reg;
        sq_next       = sq_reg;
        drem_next     = drem_reg;
        dq_next       = dq_reg;
        srad_next     = srad_reg;
        sroot_next    = sroot_reg;
        srem_next     = srem_reg;
        loop_next     = loop_reg;
        level_next    = level_reg;
        nsamp_next    = nsamp_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            len_next = cfg_data;
        end

        unique case (cw.op)
            wrms_pkg::OP_NONE: begin
            end
            wrms_pkg::OP_LOAD: begin
                if (accept) begin
                    // magnitude; -32768 gives 0x8000
                    mag_next  = s_tdata[15] ? wrms_pkg::SAMPLE_W'(~s_tdata + 16'd1)
                                            : s_tdata;
                    last_next = s_tlast;
                end
            end
            wrms_pkg::OP_SQUARE: begin
                sq_next = product[wrms_pkg::SQUARE_W-1:0];
            end
            wrms_pkg::OP_ACCUM: begin
                sum_next   = sum_reg + {{(wrms_pkg::SUM_W - wrms_pkg::SQUARE_W){1'b0}}, sq_reg};
                count_next = count_reg + wrms_pkg::COUNT_W'(1);
            end
            wrms_pkg::OP_DIV_INIT: begin
                // quotient fits 31 bits, so the upper dividend bits start as remainder
                drem_next = {1'b0, sum_reg[wrms_pkg::SUM_W-1:wrms_pkg::QUOT_W]};
                dq_next   = sum_reg[wrms_pkg::QUOT_W-1:0];
                loop_next = wrms_pkg::DIV_LAST;
            end
            wrms_pkg::OP_DIV_STEP: begin
                if (!div_diff[wrms_pkg::COUNT_W+1]) begin
                    drem_next = div_diff[wrms_pkg::COUNT_W-1:0];
                    dq_next   = {dq_reg[wrms_pkg::QUOT_W-2:0], 1'b1};
                end else begin
                    drem_next = {drem_reg[wrms_pkg::COUNT_W-2:0], dq_reg[wrms_pkg::QUOT_W-1]};
                    dq_next   = {dq_reg[wrms_pkg::QUOT_W-2:0], 1'b0};
                end
                loop_next = loop_reg - wrms_pkg::LOOP_W'(1);
            end
            wrms_pkg::OP_SQRT_INIT: begin
                srad_next  = {1'b0, dq_reg};
                sroot_next = '0;
                srem_next  = '0;
                loop_next  = wrms_pkg::SQRT_LAST;
            end
            wrms_pkg::OP_SQRT_STEP: begin
                srem_next  = sqrt_ge ? sqrt_diff[wrms_pkg::SREM_W-1:0]
                                     : sqrt_part[wrms_pkg::SREM_W-1:0];
                sroot_next = {sroot_reg[wrms_pkg::ROOT_W-2:0], sqrt_ge};
                srad_next  = {srad_reg[2*wrms_pkg::ROOT_W-3:0], 2'b00};
                loop_next  = loop_reg - wrms_pkg::LOOP_W'(1);
            end
            wrms_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    level_next    = sroot_reg;
                    nsamp_next    = count_reg;
                    m_tvalid_next = 1'b1;
                    sum_next      = '0;
                    count_next    = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= wrms_pkg::PC_IDLE;
            loop_reg     <= '0;
            len_reg      <= wrms_pkg::COUNT_W'(wrms_pkg::WINDOW_RESET);
            sum_reg      <= '0;
            count_reg    <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            loop_reg     <= loop_next;
            len_reg      <= len_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        sq_reg    <= sq_next;
        drem_reg  <= drem_next;
        dq_reg    <= dq_next;
        srad_reg  <= srad_next;
        sroot_reg <= sroot_next;
        srem_reg  <= srem_next;
        level_reg <= level_next;
        nsamp_reg <= nsamp_next;
    end

    // divider remainder stays below the divisor throughout the division
    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == wrms_pkg::PC_DIV_STEP |-> drem_reg < count_reg)
        else $error("divider remainder not below sample count");

    // a result leaves with the window cleared behind it
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == wrms_pkg::PC_EMIT && !out_busy)
        |=> m_tvalid_reg && count_reg == '0 && sum_reg == '0)
        else $error("emit did not publish result and clear window");

    // level is within Q1.15 full scale and window is never empty
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> level_reg <= 16'd32768 && nsamp_reg != '0)
        else $error("result out of range");

    // no sample is taken during the division or square root steps
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == wrms_pkg::PC_DIV_STEP || pc_reg == wrms_pkg::PC_SQRT_STEP) |-> !s_tready)
        else $error("input ready during division or root");

endmodule
